### rtl/iprs_pkg.sv
`default_nettype none
package iprs_pkg;

    // Configuration register widths and indexes
    localparam int SCALE_W     = 7;
    localparam int ROW_WIDTH_W = 12;
    localparam int CFG_DATA_W  = 12;

    localparam logic REG_SCALE     = 1'b0;
    localparam logic REG_ROW_WIDTH = 1'b1;

    // Input item kinds
    localparam logic KIND_PIXEL  = 1'b0;
    localparam logic KIND_REPLAY = 1'b1;

    // Pixel payload
    localparam int PIXEL_W = 24;

    // Descriptor handed from the sequencer to the copy emitter
    typedef struct packed {
        logic               err;
        logic               replay;
        logic               row_done;
        logic [1:0]         pad;
        logic [SCALE_W-1:0] scale;
    } iprs_item_t;

endpackage
`default_nettype wire

### rtl/iprs_line_store.sv
`default_nettype none
module iprs_line_store
    import iprs_pkg::*;
#(
    parameter int DEPTH  = 2048,
    parameter int ADDR_W = 11
) (
    input  wire logic               aclk,
    input  wire logic               wr_en,
    input  wire logic               rd_en,
    input  wire logic [ADDR_W-1:0]  addr,
    input  wire logic [PIXEL_W-1:0] wr_data,
    output logic      [PIXEL_W-1:0] rd_data
);

    logic [PIXEL_W-1:0] mem [DEPTH];
    logic [PIXEL_W-1:0] rd_data_reg;

    // Single port: write on pixel, registered read on replay
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

### rtl/iprs_ctrl.sv
`default_nettype none
module iprs_ctrl
    import iprs_pkg::*;
#(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_SCALE = 64,
    parameter int COL_W     = 11,
    parameter int VP_W      = 6
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic                  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  accept,
    input  wire logic                  kind,
    output iprs_item_t                 item,
    output logic      [COL_W-1:0]      mem_addr,
    output logic                       mem_wr_en,
    output logic                       mem_rd_en
);

    localparam int WCMP_W = (COL_W + 1 > ROW_WIDTH_W + 1) ? COL_W + 1 : ROW_WIDTH_W + 1;
    localparam int VCMP_W = SCALE_W + 1;

    logic [SCALE_W-1:0]     scale_reg;
    logic [ROW_WIDTH_W-1:0] row_width_reg;
    logic [COL_W-1:0]       column_reg;
    logic [COL_W-1:0]       column_next;
    logic [VP_W-1:0]        vpass_reg;
    logic [VP_W-1:0]        vpass_next;

    logic [SCALE_W-1:0]     scale_eff;
    logic [WCMP_W-1:0]      width_eff;
    logic                   err;
    logic                   row_done;
    logic                   vdone;
    logic [1:0]             mod_prod;
    logic [1:0]             mod_bytes;

    // Hold configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg     <= SCALE_W'(1);
            row_width_reg <= ROW_WIDTH_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SCALE:     scale_reg     <= cfg_wdata[SCALE_W-1:0];
                REG_ROW_WIDTH: row_width_reg <= cfg_wdata[ROW_WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp configuration into its legal range
    always_comb begin
        if (scale_reg == '0) begin
            scale_eff = SCALE_W'(1);
        end else if (32'(scale_reg) > MAX_SCALE) begin
            scale_eff = SCALE_W'(MAX_SCALE);
        end else begin
            scale_eff = scale_reg;
        end

        if (row_width_reg == '0) begin
            width_eff = WCMP_W'(1);
        end else if (32'(row_width_reg) > MAX_WIDTH) begin
            width_eff = WCMP_W'(MAX_WIDTH);
        end else begin
            width_eff = WCMP_W'(row_width_reg);
        end
    end

    // Decide phase, row end and padding for the offered transaction
    always_comb begin
        err      = (kind == KIND_PIXEL) != (vpass_reg == '0);
        row_done = (WCMP_W'(column_reg) + WCMP_W'(1)) >= width_eff;
        vdone    = (VCMP_W'(vpass_reg) + VCMP_W'(1)) >= VCMP_W'(scale_eff);
        // Row bytes mod 4 depend only on the two low bits of width and scale
        mod_prod  = 2'(width_eff[1:0] * scale_eff[1:0]);
        mod_bytes = 2'(mod_prod + {mod_prod[0], 1'b0});

        item.err      = err;
        item.replay   = (kind == KIND_REPLAY);
        item.row_done = row_done;
        item.pad      = 2'(~mod_bytes + 2'd1);
        item.scale    = scale_eff;

        mem_addr  = column_reg;
        mem_wr_en = accept && !err && (kind == KIND_PIXEL);
        mem_rd_en = accept && !err && (kind == KIND_REPLAY);
    end

    // Advance column and vertical pass
    always_comb begin
        column_next = column_reg;
        vpass_next  = vpass_reg;
        if (accept && !err) begin
            if (row_done) begin
                column_next = '0;
                vpass_next  = vdone ? '0 : VP_W'(vpass_reg + VP_W'(1));
            end else begin
                column_next = COL_W'(column_reg + COL_W'(1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg <= '0;
            vpass_reg  <= '0;
        end else begin
            column_reg <= column_next;
            vpass_reg  <= vpass_next;
        end
    end

    a_column_in_store: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(column_reg) < MAX_WIDTH)
        else $error("column left the line store");

    a_vpass_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(vpass_reg) < MAX_SCALE)
        else $error("vertical pass beyond scale limit");

    a_error_keeps_state: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && err |=> $stable(column_reg) && $stable(vpass_reg))
        else $error("rejected transaction changed position");

endmodule
`default_nettype wire

### rtl/iprs_emit.sv
`default_nettype none
module iprs_emit
    import iprs_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               accept,
    input  wire iprs_item_t         item,
    input  wire logic [PIXEL_W-1:0] pixel_in,
    input  wire logic [PIXEL_W-1:0] store_data,
    input  wire logic               out_ready,
    output logic                    in_ready,
    output logic                    out_valid,
    output logic      [PIXEL_W-1:0] out_pixel,
    output logic                    out_row_end,
    output logic      [1:0]         out_pad,
    output logic                    out_status,
    output logic                    out_last
);

    logic               valid_reg;
    iprs_item_t         item_reg;
    logic [PIXEL_W-1:0] pixel_reg;
    logic [SCALE_W-1:0] copy_reg;
    logic               last_copy;

    // Build the current copy
    always_comb begin
        last_copy   = item_reg.err || (copy_reg == SCALE_W'(item_reg.scale - SCALE_W'(1)));
        out_valid   = valid_reg;
        out_last    = last_copy;
        out_status  = item_reg.err;
        out_row_end = !item_reg.err && last_copy && item_reg.row_done;
        out_pad     = out_row_end ? item_reg.pad : 2'd0;
        if (item_reg.err) begin
            out_pixel = '0;
        end else if (item_reg.replay) begin
            out_pixel = store_data;
        end else begin
            out_pixel = pixel_reg;
        end
        in_ready = !valid_reg || (out_ready && last_copy);
    end

    // Load a new transaction or step through its copies
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            copy_reg  <= '0;
        end else if (accept) begin
            valid_reg <= 1'b1;
            copy_reg  <= '0;
        end else if (valid_reg && out_ready) begin
            if (last_copy) begin
                valid_reg <= 1'b0;
            end else begin
                copy_reg <= SCALE_W'(copy_reg + SCALE_W'(1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg  <= item;
            pixel_reg <= pixel_in;
        end
    end

    a_stall_holds_copy: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !out_ready |=> valid_reg && $stable(copy_reg))
        else $error("copy counter moved during stall");

    a_error_single: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && item_reg.err |-> last_copy && copy_reg == '0)
        else $error("rejected transaction emitted more than one result");

    a_copy_below_scale: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> copy_reg < item_reg.scale)
        else $error("copy counter passed scale");

endmodule
`default_nettype wire

### rtl/integer_pixel_replication_scaler.sv
`default_nettype none
// Integer pixel replication scaler. Each input pixel (s_tuser = 0) is written
// to the line store and emitted scale times; after a row of row_width pixels
// the block expects (scale-1) x row_width replay transactions (s_tuser = 1),
// each reading the next stored pixel and emitting it scale times. An item of
// the wrong kind for the current pass yields one result with status set and
// changes nothing. An item occupies the output for scale copies (one for a
// rejected item) at one output pixel per cycle while m_tready is high, set by
// the copy counter in front of the master port; the next item is taken in
// the cycle its predecessor's last copy is accepted, so items flow back to
// back at scale 1. The line store read issues on the accept edge, so its
// registered read stays hidden. The store needs no clearing pass after reset.
module integer_pixel_replication_scaler
    import iprs_pkg::*;
#(
    parameter int MAX_WIDTH = 2048,
    parameter int MAX_SCALE = 64
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // configuration write port
    input  wire logic                  cfg_wr_en,
    input  wire logic                  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    // input stream
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [23:0]           s_tdata,  // red, green, blue
    input  wire logic [0:0]            s_tuser,  // kind
    // result stream
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [31:0]           m_tdata,  // out_red, out_green, out_blue,
                                                 // row_end, pad_bytes, zero fill
    output logic      [0:0]            m_tuser,  // status
    output logic                       m_tlast
);

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int VP_W  = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

    logic               accept;
    iprs_item_t         item;
    logic [COL_W-1:0]   mem_addr;
    logic               mem_wr_en;
    logic               mem_rd_en;
    logic [PIXEL_W-1:0] pixel_in;
    logic [PIXEL_W-1:0] store_data;
    logic [PIXEL_W-1:0] out_pixel;
    logic               out_row_end;
    logic [1:0]         out_pad;
    logic               out_status;

    assign accept   = s_tvalid && s_tready;
    // Store pixels with red in the top byte
    assign pixel_in = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};

    iprs_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_SCALE (MAX_SCALE),
        .COL_W     (COL_W),
        .VP_W      (VP_W)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .accept    (accept),
        .kind      (s_tuser[0]),
        .item      (item),
        .mem_addr  (mem_addr),
        .mem_wr_en (mem_wr_en),
        .mem_rd_en (mem_rd_en)
    );

    iprs_line_store #(
        .DEPTH  (MAX_WIDTH),
        .ADDR_W (COL_W)
    ) u_line_store (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .rd_en   (mem_rd_en),
        .addr    (mem_addr),
        .wr_data (pixel_in),
        .rd_data (store_data)
    );

    iprs_emit u_emit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .item        (item),
        .pixel_in    (pixel_in),
        .store_data  (store_data),
        .out_ready   (m_tready),
        .in_ready    (s_tready),
        .out_valid   (m_tvalid),
        .out_pixel   (out_pixel),
        .out_row_end (out_row_end),
        .out_pad     (out_pad),
        .out_status  (out_status),
        .out_last    (m_tlast)
    );

    // Pack the result fields
    assign m_tdata = {5'b0, out_pad, out_row_end,
                      out_pixel[7:0], out_pixel[15:8], out_pixel[23:16]};
    assign m_tuser = out_status;

endmodule
`default_nettype wire

### sim/tb_integer_pixel_replication_scaler.sv
module tb_integer_pixel_replication_scaler;
    import iprs_pkg::*;

    localparam int   MAX_WIDTH      = 2048;
    localparam int   MAX_SCALE      = 64;
    localparam int   STALL_LIMIT    = 2000;
    localparam int   HOLD_CYCLES    = 300;
    localparam int   IDLE_PCT       = 32;
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_REJECT  = 1'b1;

    typedef struct packed {
        logic       kind;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_item_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       row_end;
        logic [1:0] pad_bytes;
        logic       status;
        logic       last;
    } pixel_copy_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic                  cfg_index = 1'b0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [23:0]           s_tdata   = '0;
    logic [0:0]            s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [31:0]           m_tdata;
    logic [0:0]            m_tuser;
    logic                  m_tlast;

    integer_pixel_replication_scaler dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #5 aclk = ~aclk;

    // Scaler mirror: stored row, position and register copies
    logic [23:0] row_copy [MAX_WIDTH];
    logic [10:0] cur_col   = '0;
    logic [5:0]  cur_pass  = '0;
    logic [6:0]  scale_reg = 7'd1;
    logic [11:0] width_reg = 12'd1;

    pixel_item_t items_to_send [$];
    pixel_copy_t copies_due [$];
    pixel_item_t cur_item;
    int          errors       = 0;
    int          src_cycles   = 0;
    int          sink_cycles  = 0;
    int          stall_cycles = 0;
    int          hold_left    = 0;
    logic        hold_done    = 1'b0;
    logic        hold_arm     = 1'b0;

    function automatic int eff_scale(logic [6:0] v);
        if (v == 0) return 1;
        if (v > MAX_SCALE) return MAX_SCALE;
        return int'(v);
    endfunction

    function automatic int eff_width(logic [11:0] v);
        if (v == 0) return 1;
        if (v > MAX_WIDTH) return MAX_WIDTH;
        return int'(v);
    endfunction

    // Random idling, suppressed in a quiet window at the end of each period of the cycle count
    function automatic logic take_break(int cyc);
        return (cyc % 5000 < 3500) && ($urandom_range(99) < IDLE_PCT);
    endfunction

    // Expand one accepted transaction into its output copies
    function automatic void replicate_pixel(pixel_item_t it);
        int          s;
        int          w;
        logic [23:0] px;
        logic        row_done;
        logic [1:0]  pad;
        pixel_copy_t r;
        s = eff_scale(scale_reg);
        w = eff_width(width_reg);
        if ((it.kind == KIND_PIXEL) != (cur_pass == 0)) begin
            r        = '0;
            r.status = STATUS_REJECT;
            r.last   = 1'b1;
            copies_due.push_back(r);
            return;
        end
        if (it.kind == KIND_PIXEL) begin
            px = {it.red, it.green, it.blue};
            row_copy[cur_col] = px;
        end else begin
            px = row_copy[cur_col];
        end
        row_done = (int'(cur_col) + 1 >= w);
        pad      = 2'((4 - ((w * s * 3) & 3)) & 3);
        for (int n = 0; n < s; n++) begin
            r.red       = px[23:16];
            r.green     = px[15:8];
            r.blue      = px[7:0];
            r.last      = (n == s - 1);
            r.row_end   = r.last && row_done;
            r.pad_bytes = r.row_end ? pad : 2'd0;
            r.status    = STATUS_OK;
            copies_due.push_back(r);
        end
        if (row_done) begin
            cur_col  = '0;
            cur_pass = (int'(cur_pass) + 1 >= s) ? 6'd0 : cur_pass + 6'd1;
        end else begin
            cur_col = cur_col + 11'd1;
        end
    endfunction

    function automatic int mismatch(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    // Driver: predict on accept, then offer the next pending item
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) replicate_pixel(cur_item);
            if (!s_tvalid || s_tready) begin
                if (items_to_send.size() != 0 && !take_break(src_cycles)) begin
                    cur_item  = items_to_send.pop_front();
                    s_tdata  <= {cur_item.blue, cur_item.green, cur_item.red};
                    s_tuser  <= cur_item.kind;
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
            src_cycles++;
        end
    end

    // Receiver ready: random stalls plus one long hold-off once armed
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (hold_arm && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !take_break(sink_cycles);
            end
            sink_cycles++;
        end
    end

    // Monitor: compare each result transaction with the oldest expected copy
    always @(posedge aclk) begin
        pixel_copy_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (copies_due.size() == 0) begin
                $display("%0t: expected nothing, actual tdata %h status %b last %b",
                         $time, m_tdata, m_tuser, m_tlast);
                errors++;
            end else begin
                want = copies_due.pop_front();
                errors += mismatch("out_red", want.red, m_tdata[7:0]);
                errors += mismatch("out_green", want.green, m_tdata[15:8]);
                errors += mismatch("out_blue", want.blue, m_tdata[23:16]);
                errors += mismatch("row_end", 8'(want.row_end), 8'(m_tdata[24]));
                errors += mismatch("pad_bytes", 8'(want.pad_bytes), 8'(m_tdata[26:25]));
                errors += mismatch("zero fill", 8'd0, 8'(m_tdata[31:27]));
                errors += mismatch("status", 8'(want.status), 8'(m_tuser));
                errors += mismatch("last", 8'(want.last), 8'(m_tlast));
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("tb_integer_pixel_replication_scaler NOT OK");
            $finish;
        end
    end

    task automatic write_reg(logic idx, int val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[CFG_DATA_W-1:0];
        if (idx == REG_SCALE) scale_reg = val[6:0];
        else width_reg = val[11:0];
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        while (items_to_send.size() != 0 || s_tvalid || copies_due.size() != 0)
            @(negedge aclk);
    endtask

    function automatic void push_item(logic kind, logic [23:0] rgb);
        items_to_send.push_back({kind, rgb});
    endfunction

    // Queue well-formed rows with random content, a share of them broken by
    // the wrong kind; optionally keep going until the image is complete
    task automatic send_rows(int n, int noise_pct, logic to_boundary);
        int          c;
        int          vp;
        int          s;
        int          w;
        int          i;
        pixel_item_t it;
        c  = cur_col;
        vp = cur_pass;
        s  = eff_scale(scale_reg);
        w  = eff_width(width_reg);
        i  = 0;
        @(negedge aclk);
        while (i < n || (to_boundary && (c != 0 || vp != 0))) begin
            it.red   = 8'($urandom_range(255));
            it.green = 8'($urandom_range(255));
            it.blue  = 8'($urandom_range(255));
            it.kind  = (vp == 0) ? KIND_PIXEL : KIND_REPLAY;
            if ($urandom_range(99) < noise_pct) begin
                it.kind = (vp == 0) ? KIND_REPLAY : KIND_PIXEL;
            end else if (c + 1 >= w) begin
                c  = 0;
                vp = (vp + 1 >= s) ? 0 : vp + 1;
            end else begin
                c++;
            end
            items_to_send.push_back(it);
            i++;
        end
        wait_drained();
    endtask

    initial begin
        int rand_items;
        int sc;
        int wd;
        int n;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Two-pixel rows at scale 3, with rejects in both phases
        write_reg(REG_SCALE, 3);
        write_reg(REG_ROW_WIDTH, 2);
        @(negedge aclk);
        push_item(KIND_REPLAY, 24'h000000);
        push_item(KIND_PIXEL, 24'hff00ff);
        push_item(KIND_PIXEL, 24'h00ff00);
        push_item(KIND_PIXEL, 24'h123456);
        repeat (4) push_item(KIND_REPLAY, 24'hffffff);
        wait_drained();

        // Zero registers act as one
        write_reg(REG_SCALE, 0);
        write_reg(REG_ROW_WIDTH, 0);
        @(negedge aclk);
        push_item(KIND_PIXEL, 24'hffffff);
        push_item(KIND_PIXEL, 24'h000000);
        push_item(KIND_REPLAY, 24'h000000);
        wait_drained();

        // Scale above the cap, then shrink it in the middle of the replay passes
        write_reg(REG_SCALE, 127);
        write_reg(REG_ROW_WIDTH, 1);
        @(negedge aclk);
        push_item(KIND_PIXEL, 24'h5a96c3);
        repeat (3) push_item(KIND_REPLAY, 24'h000000);
        wait_drained();
        write_reg(REG_SCALE, 2);
        @(negedge aclk);
        push_item(KIND_REPLAY, 24'h000000);
        push_item(KIND_PIXEL, 24'h3c3c3c);
        push_item(KIND_REPLAY, 24'h000000);
        wait_drained();

        // Shrink the row width in the middle of the input pass
        write_reg(REG_ROW_WIDTH, 5);
        send_rows(3, 0, 1'b0);
        write_reg(REG_ROW_WIDTH, 2);
        send_rows(3, 0, 1'b0);

        // Random settings, each phase may stop in the middle of a row
        rand_items = 0;
        while (rand_items < 30) begin
            case ($urandom_range(9))
                0:       sc = 0;
                1:       sc = $urandom_range(MAX_SCALE + 1, 127);
                2:       sc = MAX_SCALE;
                default: sc = $urandom_range(1, 4);
            endcase
            case ($urandom_range(7))
                0:       wd = 0;
                1:       wd = $urandom_range(7, 24);
                default: wd = $urandom_range(1, 6);
            endcase
            // a wider row during replay would read entries never stored
            if (cur_pass != 0 && eff_width(wd) > eff_width(width_reg)) wd = width_reg;
            write_reg(REG_SCALE, sc);
            write_reg(REG_ROW_WIDTH, wd);
            n = $urandom_range(4, 10);
            send_rows(n, 10, 1'b0);
            rand_items += n;
        end

        // Close the open image, then run every vertical pass at the cap
        write_reg(REG_SCALE, 1);
        send_rows(0, 0, 1'b1);
        write_reg(REG_SCALE, 100);
        write_reg(REG_ROW_WIDTH, 1);
        send_rows(MAX_SCALE, 0, 1'b0);

        // Short image under a long receiver hold-off
        hold_arm <= 1'b1;
        write_reg(REG_SCALE, 2);
        write_reg(REG_ROW_WIDTH, 4);
        send_rows(16, 3, 1'b0);

        repeat (50) @(posedge aclk);
        if (errors == 0) begin
            $display("tb_integer_pixel_replication_scaler OK");
        end else begin
            $display("tb_integer_pixel_replication_scaler NOT OK");
        end
        $finish;
    end

endmodule
